// ===== sv/rnu_pkg.sv =====
// ----------------------------------------------------------------------------
// rnu_pkg
// Shared widths and status codes for the rational normalizer.
// ----------------------------------------------------------------------------
package rnu_pkg;

    localparam int DATA_W = 64;                 // signed operand width
    localparam int MAG_W  = DATA_W - 1;         // magnitude width of a legal operand
    localparam int CNT_W  = $clog2(MAG_W);      // divide step counter width

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + MAG_W + 7) / 8) * 8;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ===== sv/rational_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// rational_normalizer_unit
// Reduces a signed 64-bit fraction to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// One request is worked at a time; s_tready is high only while the unit is
// idle. A zero denominator or a most negative operand goes straight to the
// done state. Otherwise a binary gcd runs first, one step per cycle (each step
// drops at least one bit from the operand pair), then two restoring divides of
// 63 quotient bits each produce the reduced numerator and denominator. All of
// this work goes through one shared 64-bit subtractor. The result sits in an
// output register, and the next request may be taken while it waits for
// m_tready.
module rational_normalizer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rnu_pkg::S_TDATA_W-1:0]    s_tdata,   // num_in[63:0], den_in[127:64]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rnu_pkg::M_TDATA_W-1:0]    m_tdata,   // num_out[63:0], den_out[126:64], zero pad
    output logic [rnu_pkg::STATUS_W-1:0]     m_tuser    // status[1:0]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVA = 3'd2;
    localparam logic [2:0] S_DIVB = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [rnu_pkg::CNT_W-1:0] DIV_LAST = rnu_pkg::CNT_W'(rnu_pkg::MAG_W - 1);
    localparam int PAD_W = rnu_pkg::M_TDATA_W - rnu_pkg::DATA_W - rnu_pkg::MAG_W;

    logic [2:0]                      state_reg, state_next;
    logic [rnu_pkg::MAG_W-1:0]       x_reg, x_next;
    logic [rnu_pkg::MAG_W-1:0]       y_reg, y_next;
    logic [rnu_pkg::MAG_W-1:0]       a_reg, a_next;     // numerator magnitude, then quotient
    logic [rnu_pkg::MAG_W-1:0]       b_reg, b_next;     // denominator magnitude, then quotient
    logic                            neg_reg, neg_next;
    logic [rnu_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [rnu_pkg::CNT_W-1:0]       cnt_reg, cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [rnu_pkg::DATA_W-1:0]      out_num_reg, out_num_next;
    logic [rnu_pkg::MAG_W-1:0]       out_den_reg, out_den_next;
    logic [rnu_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [rnu_pkg::DATA_W-1:0]      num_in, den_in;
    logic [rnu_pkg::DATA_W-1:0]      num_neg, den_neg;
    logic                            in_zero_den, in_ovf;

    logic [rnu_pkg::DATA_W-1:0]      op_a, op_b;
    logic [rnu_pkg::DATA_W:0]        diff;
    logic                            borrow;
    logic [rnu_pkg::DATA_W-1:0]      abs_diff;
    logic [rnu_pkg::MAG_W-1:0]       div_q;             // dividend bits feeding the divider
    logic                            x_zero;
    logic                            accept;
    logic                            out_free;

    assign num_in  = s_tdata[rnu_pkg::DATA_W-1:0];
    assign den_in  = s_tdata[2*rnu_pkg::DATA_W-1:rnu_pkg::DATA_W];
    assign num_neg = ~num_in + rnu_pkg::DATA_W'(1);
    assign den_neg = ~den_in + rnu_pkg::DATA_W'(1);
    assign in_zero_den = (den_in == '0);
    assign in_ovf = (num_in == {1'b1, {rnu_pkg::MAG_W{1'b0}}})
                 || (den_in == {1'b1, {rnu_pkg::MAG_W{1'b0}}});

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign x_zero   = (x_reg == '0);
    assign div_q    = (state_reg == S_DIVB) ? b_reg : a_reg;

    // shared subtractor: gcd compares x and y, the divider trial-subtracts y
    always_comb
    begin
        if (state_reg == S_GCD)
        begin
            op_a = {1'b0, x_reg};
        end
        else
        begin
            op_a = {x_reg, div_q[rnu_pkg::MAG_W-1]};
        end
        op_b     = {1'b0, y_reg};
        diff     = {1'b0, op_a} - {1'b0, op_b};
        borrow   = diff[rnu_pkg::DATA_W];
        abs_diff = borrow ? (~diff[rnu_pkg::DATA_W-1:0] + rnu_pkg::DATA_W'(1))
                          : diff[rnu_pkg::DATA_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        neg_next        = neg_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_num_next    = out_num_reg;
        out_den_next    = out_den_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_next   = num_in[rnu_pkg::DATA_W-1] ? num_neg[rnu_pkg::MAG_W-1:0]
                                                         : num_in[rnu_pkg::MAG_W-1:0];
                    b_next   = den_in[rnu_pkg::DATA_W-1] ? den_neg[rnu_pkg::MAG_W-1:0]
                                                         : den_in[rnu_pkg::MAG_W-1:0];
                    x_next   = a_next;
                    y_next   = b_next;
                    neg_next = num_in[rnu_pkg::DATA_W-1] ^ den_in[rnu_pkg::DATA_W-1];
                    if (in_zero_den || in_ovf)
                    begin
                        status_next = in_zero_den ? rnu_pkg::ST_ZERO_DEN : rnu_pkg::ST_OVERFLOW;
                        a_next      = '0;
                        b_next      = '0;
                        neg_next    = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = rnu_pkg::ST_OK;
                        state_next  = S_GCD;
                    end
                end
            end

            S_GCD:
            begin
                // common factors of two are stripped from a and b as well,
                // so y alone divides them once x reaches zero
                if (x_zero)
                begin
                    x_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIVA;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else
                begin
                    // both odd: difference is even, halve it in the same step
                    x_next = abs_diff[rnu_pkg::MAG_W:1];
                    if (borrow)
                    begin
                        y_next = x_reg;
                    end
                end
            end

            S_DIVA, S_DIVB:
            begin
                x_next = borrow ? op_a[rnu_pkg::MAG_W-1:0] : diff[rnu_pkg::MAG_W-1:0];
                if (state_reg == S_DIVA)
                begin
                    a_next = {a_reg[rnu_pkg::MAG_W-2:0], !borrow};
                end
                else
                begin
                    b_next = {b_reg[rnu_pkg::MAG_W-2:0], !borrow};
                end
                cnt_next = cnt_reg + rnu_pkg::CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    x_next     = '0;
                    state_next = (state_reg == S_DIVA) ? S_DIVB : S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_num_next    = neg_reg ? (~{1'b0, a_reg} + rnu_pkg::DATA_W'(1))
                                              : {1'b0, a_reg};
                    out_den_next    = b_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        neg_reg        <= neg_next;
        status_reg     <= status_next;
        out_num_reg    <= out_num_next;
        out_den_reg    <= out_den_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_den_reg, out_num_reg};
    assign m_tuser  = out_status_reg;

    // gcd divisor never vanishes while the loop runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (y_reg != '0))
        else $error("gcd divisor reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == rnu_pkg::ST_OK) |-> (out_den_reg != '0))
        else $error("ok result with zero denominator");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rnu_pkg::ST_OK) |-> (out_den_reg == '0) && (out_num_reg == '0))
        else $error("error result carries nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == rnu_pkg::ST_OK) || (m_tuser == rnu_pkg::ST_ZERO_DEN)
                     || (m_tuser == rnu_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVA) && (cnt_reg == DIV_LAST) |=> (state_reg == S_DIVB))
        else $error("divide sequence skipped denominator pass");

endmodule

// ===== tb/tb_rational_normalizer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_normalizer_unit
// Self-checking bench for the fraction reducer. A directed table covers the
// zero-denominator and most-negative cases, the signs and the range limits.
// Random requests follow: full-width values, products with a built-in common
// factor, and small values. Each result is checked against a gcd-based
// reduction computed in the bench. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module tb_rational_normalizer_unit;

    localparam logic [rnu_pkg::DATA_W-1:0] MAX_POS = {1'b0, {(rnu_pkg::DATA_W-1){1'b1}}};
    localparam logic [rnu_pkg::DATA_W-1:0] MIN_NEG = {1'b1, {(rnu_pkg::DATA_W-1){1'b0}}};
    localparam logic [rnu_pkg::DATA_W-1:0] NEG_MAX = MIN_NEG + 1;
    localparam logic [rnu_pkg::DATA_W-1:0] NEG_ONE = '1;
    localparam logic [rnu_pkg::MAG_W-1:0]  MAX_MAG = '1;
    localparam int                         RANDOM_REQUESTS = 1030;

    typedef struct packed {
        logic [rnu_pkg::DATA_W-1:0]   num;
        logic [rnu_pkg::MAG_W-1:0]    den;
        logic [rnu_pkg::STATUS_W-1:0] status;
    } frac_t;

    typedef struct packed {
        logic [rnu_pkg::DATA_W-1:0] num;
        logic [rnu_pkg::DATA_W-1:0] den;
        bit                         given;   // want is typed in, otherwise computed
        frac_t                      want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rnu_pkg::S_TDATA_W-1:0]   s_tdata;    // num_in[63:0], den_in[127:64]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rnu_pkg::M_TDATA_W-1:0]   m_tdata;    // num_out[63:0], den_out[126:64], zero pad
    logic [rnu_pkg::STATUS_W-1:0]    m_tuser;    // status[1:0]

    frac_t pending_fracs[$];
    int    mismatches   = 0;
    int    results_seen = 0;
    int    burst_left   = 0;

    dir_row_t directed_table [25] = '{
        '{64'd0,   64'd0,   1'b1, '{64'd0, 63'd0, rnu_pkg::ST_ZERO_DEN}},
        '{MIN_NEG, 64'd0,   1'b1, '{64'd0, 63'd0, rnu_pkg::ST_ZERO_DEN}},
        '{MAX_POS, 64'd0,   1'b1, '{64'd0, 63'd0, rnu_pkg::ST_ZERO_DEN}},
        '{MIN_NEG, 64'd1,   1'b1, '{64'd0, 63'd0, rnu_pkg::ST_OVERFLOW}},
        '{64'd1,   MIN_NEG, 1'b1, '{64'd0, 63'd0, rnu_pkg::ST_OVERFLOW}},
        '{MIN_NEG, MIN_NEG, 1'b1, '{64'd0, 63'd0, rnu_pkg::ST_OVERFLOW}},
        '{64'd0,   MIN_NEG, 1'b1, '{64'd0, 63'd0, rnu_pkg::ST_OVERFLOW}},
        '{MIN_NEG, NEG_ONE, 1'b1, '{64'd0, 63'd0, rnu_pkg::ST_OVERFLOW}},
        '{64'd0,   64'd5,   1'b1, '{64'd0, 63'd1, rnu_pkg::ST_OK}},
        '{64'd0,   64'hFFFF_FFFF_FFFF_FFF9, 1'b1, '{64'd0, 63'd1, rnu_pkg::ST_OK}},
        '{64'd0,   MAX_POS, 1'b1, '{64'd0, 63'd1, rnu_pkg::ST_OK}},
        '{MAX_POS, MAX_POS, 1'b1, '{64'd1, 63'd1, rnu_pkg::ST_OK}},
        '{NEG_MAX, MAX_POS, 1'b1, '{NEG_ONE, 63'd1, rnu_pkg::ST_OK}},
        '{MAX_POS, NEG_MAX, 1'b1, '{NEG_ONE, 63'd1, rnu_pkg::ST_OK}},
        '{NEG_MAX, NEG_MAX, 1'b1, '{64'd1, 63'd1, rnu_pkg::ST_OK}},
        '{MAX_POS, 64'd1,   1'b1, '{MAX_POS, 63'd1, rnu_pkg::ST_OK}},
        '{64'd1,   MAX_POS, 1'b1, '{64'd1, MAX_MAG, rnu_pkg::ST_OK}},
        '{MAX_POS, NEG_ONE, 1'b1, '{NEG_MAX, 63'd1, rnu_pkg::ST_OK}},
        '{NEG_ONE, NEG_ONE, 1'b1, '{64'd1, 63'd1, rnu_pkg::ST_OK}},
        '{64'd1,   NEG_ONE, 1'b1, '{NEG_ONE, 63'd1, rnu_pkg::ST_OK}},
        '{64'd6,   64'hFFFF_FFFF_FFFF_FFFC, 1'b0, '0},
        '{64'hFFFF_FFFF_FFFF_FFF4, 64'd18, 1'b0, '0},
        '{64'h4000_0000_0000_0000, 64'h2000_0000_0000_0000, 1'b0, '0},
        '{NEG_ONE, MAX_POS, 1'b0, '0},
        '{64'h0123_4567_89AB_CDEF, 64'h0FED_CBA9_8765_4321, 1'b0, '0}
    };

    rational_normalizer_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [rnu_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sign goes to the numerator, both magnitudes divided by their gcd
    function automatic frac_t reduce_fraction(logic [rnu_pkg::DATA_W-1:0] num,
                                              logic [rnu_pkg::DATA_W-1:0] den);
        frac_t                      res;
        logic [rnu_pkg::DATA_W-1:0] a;
        logic [rnu_pkg::DATA_W-1:0] b;
        logic [rnu_pkg::DATA_W-1:0] x;
        logic [rnu_pkg::DATA_W-1:0] y;
        logic [rnu_pkg::DATA_W-1:0] r;
        bit                         neg;
        res = '0;
        if (den == '0)
            res.status = rnu_pkg::ST_ZERO_DEN;
        else if (num == MIN_NEG || den == MIN_NEG)
            res.status = rnu_pkg::ST_OVERFLOW;
        else
        begin
            neg = num[rnu_pkg::DATA_W-1] ^ den[rnu_pkg::DATA_W-1];
            a = num[rnu_pkg::DATA_W-1] ? -num : num;
            b = den[rnu_pkg::DATA_W-1] ? -den : den;
            x = a;
            y = b;
            while (y != '0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            a = a / x;
            b = b / x;
            res.num    = (neg && a != '0) ? -a : a;
            res.den    = b[rnu_pkg::MAG_W-1:0];
            res.status = rnu_pkg::ST_OK;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [rnu_pkg::DATA_W-1:0] got,
                                   logic [rnu_pkg::DATA_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(logic [rnu_pkg::DATA_W-1:0] num,
                                logic [rnu_pkg::DATA_W-1:0] den,
                                frac_t want);
        int gap;
        s_tdata  <= {den, num};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_fracs.push_back(want);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {rand64(), rand64()};
            // short gaps land while busy, long ones reach past the gcd and divides
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 320);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain_requests();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_fracs.size() != 0);
    endtask

    task automatic make_random(output logic [rnu_pkg::DATA_W-1:0] num,
                               output logic [rnu_pkg::DATA_W-1:0] den);
        logic [rnu_pkg::DATA_W-1:0] specials [6];
        logic [rnu_pkg::DATA_W-1:0] g;
        int                         kind;
        int                         k;
        specials = '{64'd0, 64'd1, NEG_ONE, MAX_POS, MIN_NEG, NEG_MAX};
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            num = specials[$urandom_range(0, 5)];
            den = specials[$urandom_range(0, 5)];
        end
        else if (kind < 12)
        begin
            num = rand64();
            den = '0;
        end
        else if (kind < 40)
        begin
            num = rand64();
            den = rand64();
        end
        else if (kind < 80)
        begin
            // common factor of up to k bits, cofactors sized so the products stay below 2^62
            k = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                g = 64'd1 << $urandom_range(0, k - 1);
            else
                g = rand64() & ((64'd1 << k) - 64'd1);
            if (g == '0)
                g = 64'd1;
            num = (rand64() & ((64'd1 << (62 - k)) - 64'd1)) * g;
            den = (rand64() & ((64'd1 << (62 - k)) - 64'd1)) * g;
            if ($urandom_range(0, 1))
                num = -num;
            if ($urandom_range(0, 1))
                den = -den;
        end
        else
        begin
            num = 64'($urandom_range(0, 1000));
            den = 64'($urandom_range(0, 1000));
            if ($urandom_range(0, 1))
                num = -num;
            if ($urandom_range(0, 1))
                den = -den;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        frac_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_fracs.size() == 0)
                report_mismatch("unexpected result", m_tdata[rnu_pkg::DATA_W-1:0], '0);
            else
            begin
                want = pending_fracs.pop_front();
                if (m_tdata[rnu_pkg::DATA_W-1:0] !== want.num)
                    report_mismatch("num_out", m_tdata[rnu_pkg::DATA_W-1:0], want.num);
                if (m_tdata[rnu_pkg::DATA_W+rnu_pkg::MAG_W-1:rnu_pkg::DATA_W] !== want.den)
                    report_mismatch("den_out",
                        64'(m_tdata[rnu_pkg::DATA_W+rnu_pkg::MAG_W-1:rnu_pkg::DATA_W]),
                        64'(want.den));
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
            end
        end
    end

    // output side: stall patterns in phases, plus one long hold-off
    initial
    begin
        int  hold_left;
        int  phase_left;
        int  mode;
        bit  hold_done;
        hold_left  = 0;
        phase_left = 0;
        mode       = 0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 3000;
                m_tready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(50, 600);
                end
                phase_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (phase_left % 5 == 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        logic [rnu_pkg::DATA_W-1:0] num;
        logic [rnu_pkg::DATA_W-1:0] den;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_request(directed_table[i].num, directed_table[i].den,
                         directed_table[i].given ? directed_table[i].want
                             : reduce_fraction(directed_table[i].num,
                                               directed_table[i].den));
        drain_requests();

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
                drain_requests();
            make_random(num, den);
            send_request(num, den, reduce_fraction(num, den));
        end
        drain_requests();
        repeat (300) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rnu_pkg.sv
sv/rational_normalizer_unit.sv
tb/tb_rational_normalizer_unit.sv
